// File: src/xcfp_pkg.sv
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

  localparam logic [7:0] MAX_PAYLOAD     = 8'd76;
  localparam logic [7:0] START_BYTE_RST  = 8'hAA;

  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BADSUM   = 3'd2,
    ST_BADSTART = 3'd3,
    ST_TOOLONG  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    PH_WAIT  = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_TYPE  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_first;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] data_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
  } out_item_t;

endpackage

// File: src/xcfp_in_stage.sv
// Input register stage: holds one accepted item for the parser.
module xcfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xcfp_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output xcfp_pkg::in_item_t item_o
);
  import xcfp_pkg::*;

  logic     valid_d, valid_q;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: src/xcfp_parser.sv
// Frame state machine: per-byte state update and result generation.
module xcfp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               item_valid_i,
  input  xcfp_pkg::in_item_t item_i,
  input  logic               out_free_i,
  output logic               advance_o,
  output logic               res_valid_o,
  output xcfp_pkg::out_item_t res_o
);
  import xcfp_pkg::*;

  phase_e     phase_d, phase_q;
  logic [7:0] left_d, left_q;
  logic [7:0] xor_d, xor_q;
  logic [7:0] type_d, type_q;
  logic [7:0] len_d, len_q;
  logic [7:0] start_q;
  logic [7:0] b;
  logic [7:0] left_dec;

  assign b        = item_i.rx_byte;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    xor_d       = xor_q;
    type_d      = type_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_PAYLOAD, data_byte: 8'd0, frame_type: 8'd0,
                    frame_length: 8'd0};
    if (item_i.packet_first) begin
      if (b != start_q) begin
        phase_d     = PH_WAIT;
        res_valid_o = 1'b1;
        res_o.status = ST_BADSTART;
      end else begin
        phase_d = PH_LEN;
      end
    end else begin
      case (phase_q)
        PH_LEN: begin
          if (b > MAX_PAYLOAD) begin
            phase_d            = PH_WAIT;
            res_valid_o        = 1'b1;
            res_o.status       = ST_TOOLONG;
            res_o.frame_length = b;
          end else begin
            len_d   = b;
            left_d  = b;
            xor_d   = 8'd0;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_d  = b;
          phase_d = (left_q == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          xor_d  = xor_q ^ b;
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PH_CHECK;
          end
          res_valid_o        = 1'b1;
          res_o.status       = ST_PAYLOAD;
          res_o.data_byte    = b;
          res_o.frame_type   = type_q;
          res_o.frame_length = len_q;
        end
        PH_CHECK: begin
          phase_d            = PH_WAIT;
          res_valid_o        = 1'b1;
          res_o.status       = (b == xor_q) ? ST_GOOD : ST_BADSUM;
          res_o.frame_type   = type_q;
          res_o.frame_length = len_q;
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  assign advance_o = item_valid_i && (!res_valid_o || out_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      left_q  <= 8'd0;
      xor_q   <= 8'd0;
      type_q  <= 8'd0;
      len_q   <= 8'd0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      xor_q   <= xor_d;
      type_q  <= type_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
    end else if (cfg_we_i) begin
      start_q <= cfg_data_i;
    end
  end

endmodule

// File: src/xcfp_out_stage.sv
// Output register stage: holds one result item until the consumer takes it.
module xcfp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  xcfp_pkg::out_item_t res_i,
  input  logic                advance_i,
  output logic                out_free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xcfp_pkg::out_item_t out_item_o
);
  import xcfp_pkg::*;

  logic      valid_d, valid_q;
  out_item_t item_q;
  logic      load;

  assign out_free_o = !valid_q || out_ready_i;
  assign load       = advance_i && res_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// File: src/xor_checked_frame_parser.sv
// Top level of the XOR-checked frame parser.
// Throughput: one byte per cycle while the output is not stalled; input and
// output registers with the parser state update between them set that figure.
// Reset: asynchronous, active low; parser waits for a packet start and
// the start byte register returns to 0xAA.
module xor_checked_frame_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xcfp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xcfp_pkg::out_item_t out_item_o
);
  import xcfp_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  logic      out_free;
  logic      res_valid;
  out_item_t res;

  xcfp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  xcfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .item_valid_i(item_valid),
    .item_i      (item),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  xcfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .advance_i  (advance),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// File: src/xcfp_checker.sv
// Port-level assertions for the XOR-checked frame parser, bound to the top level.
module xcfp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [7:0]          cfg_data_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input xcfp_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input xcfp_pkg::out_item_t out_item_o
);
  import xcfp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_PAYLOAD |-> out_item_o.data_byte == 8'd0)
    else $error("data byte nonzero on a verdict item");

  a_badstart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_BADSTART
      |-> out_item_o.frame_type == 8'd0 && out_item_o.frame_length == 8'd0)
    else $error("bad start item carries type or length");

  a_toolong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_TOOLONG
      |-> out_item_o.frame_length > MAX_PAYLOAD && out_item_o.frame_type == 8'd0)
    else $error("length too long item with legal length");

endmodule

bind xor_checked_frame_parser xcfp_checker u_xcfp_checker (.*);

// File: dv/tb_top.sv
// Testbench for xor_checked_frame_parser: directed and random framed byte streams, model and scoreboard.
module tb_top;
  import xcfp_pkg::*;

  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int ITEMS_PER_PHASE = 275;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  xor_checked_frame_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // parser model state
  logic [7:0] m_start = START_BYTE_RST;
  phase_e     m_phase = PH_WAIT;
  logic [7:0] m_left = 8'h00;
  logic [7:0] m_xor = 8'h00;
  logic [7:0] m_type = 8'h00;
  logic [7:0] m_len = 8'h00;

  in_item_t  tx_bytes[$];
  out_item_t predicted_out[$];

  int n_errors = 0;
  int n_pushed = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cyc = 0;
  int rx_mode = 0;
  int idle_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void model_parse(in_item_t it);
    out_item_t r;
    bit        has_out;
    r = '0;
    has_out = 1'b0;
    if (it.packet_first) begin
      if (it.rx_byte != m_start) begin
        m_phase = PH_WAIT;
        r.status = ST_BADSTART;
        has_out = 1'b1;
      end else begin
        m_phase = PH_LEN;
      end
    end else begin
      case (m_phase)
        PH_LEN: begin
          if (it.rx_byte > MAX_PAYLOAD) begin
            m_phase = PH_WAIT;
            r.status = ST_TOOLONG;
            r.frame_length = it.rx_byte;
            has_out = 1'b1;
          end else begin
            m_len = it.rx_byte;
            m_left = it.rx_byte;
            m_xor = 8'h00;
            m_phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          m_type = it.rx_byte;
          m_phase = (m_left == 8'h00) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          m_xor = m_xor ^ it.rx_byte;
          m_left = m_left - 8'd1;
          if (m_left == 8'h00) m_phase = PH_CHECK;
          r.status = ST_PAYLOAD;
          r.data_byte = it.rx_byte;
          r.frame_type = m_type;
          r.frame_length = m_len;
          has_out = 1'b1;
        end
        PH_CHECK: begin
          m_phase = PH_WAIT;
          r.status = (it.rx_byte == m_xor) ? ST_GOOD : ST_BADSUM;
          r.frame_type = m_type;
          r.frame_length = m_len;
          has_out = 1'b1;
        end
        default: begin
          m_phase = PH_WAIT;
        end
      endcase
    end
    if (has_out) predicted_out.push_back(r);
  endfunction

  task automatic report_err(string what);
    $display("ERROR @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  task automatic check_out(out_item_t got);
    out_item_t want;
    if (predicted_out.size() == 0) begin
      report_err($sformatf("unexpected item status=%0d data=%02h", got.status, got.data_byte));
      return;
    end
    want = predicted_out.pop_front();
    if (got.status != want.status)
      report_err($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.data_byte != want.data_byte)
      report_err($sformatf("data_byte got %02h want %02h", got.data_byte, want.data_byte));
    if (got.frame_type != want.frame_type)
      report_err($sformatf("frame_type got %02h want %02h", got.frame_type, want.frame_type));
    if (got.frame_length != want.frame_length)
      report_err($sformatf("frame_length got %0d want %0d", got.frame_length,
                           want.frame_length));
  endtask

  // sender: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) model_parse(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          in_item_i <= tx_bytes.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern is re-chosen at random among always ready, a fixed pattern and random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_out(out_item_o);
      rx_cyc++;
      if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= (rx_cyc % 7 != 3) && (rx_cyc % 5 != 0);
        default: out_ready_i <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic first);
    in_item_t it;
    it.rx_byte = b;
    it.packet_first = first;
    tx_bytes.push_back(it);
    n_pushed++;
  endtask

  // start, length, type, payload, checksum; stops after keep bytes
  task automatic push_frame(int len, bit good, int keep);
    logic [7:0] chk;
    logic [7:0] d;
    int         cnt;
    chk = 8'h00;
    cnt = 0;
    if (cnt < keep) push_byte(m_start, 1'b1);
    cnt++;
    if (cnt < keep) push_byte(len[7:0], 1'b0);
    cnt++;
    if (cnt < keep) push_byte(8'($urandom_range(0, 255)), 1'b0);
    cnt++;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(0, 255));
      chk = chk ^ d;
      if (cnt < keep) push_byte(d, 1'b0);
      cnt++;
    end
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    if (cnt < keep) push_byte(chk, 1'b0);
  endtask

  task automatic run_random(int n_items);
    int base;
    int kind;
    int len;
    base = n_pushed;
    while (n_pushed - base < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(0, 99);
        if (len < 90) len = $urandom_range(0, 12);
        else if (len < 97) len = $urandom_range(13, 75);
        else len = int'(MAX_PAYLOAD);
        push_frame(len, $urandom_range(0, 4) != 0, len + 4);
        if ($urandom_range(0, 9) < 3)
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 80) begin
        push_byte(m_start, 1'b1);
        push_byte(($urandom_range(0, 3) == 0) ? 8'd77 : 8'($urandom_range(77, 255)), 1'b0);
      end else if (kind < 88) begin
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (kind < 95) begin
        len = $urandom_range(0, 12);
        push_frame(len, 1'b1, $urandom_range(1, len + 3));
      end else begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid_i || predicted_out.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_start(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_start = v;
  endtask

  initial begin
    logic [7:0] starts[5];
    starts = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'($urandom_range(0, 255)), 8'hAA};
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset start byte
    push_byte(8'hAA, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b1); push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h55, 1'b1);
    push_byte(8'hAA, 1'b1); push_byte(8'd77, 1'b0);
    push_byte(8'hAA, 1'b1); push_byte(8'hFF, 1'b0);
    // restart mid-payload
    push_byte(8'hAA, 1'b1); push_byte(8'h02, 1'b0); push_byte(8'h5A, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'hAA, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'h12, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h3C, 1'b0);
    // zero length, nonzero checksum
    push_byte(8'hAA, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);

    run_random(ITEMS_PER_PHASE);
    foreach (starts[i]) begin
      wait_idle();
      write_start(starts[i]);
      run_random(ITEMS_PER_PHASE);
    end
    wait_idle();

    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
